// ===== hw/rtl/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants of the bitmap text console renderer.
// ----------------------------------------------------------------------------
package btc_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int CELL_SIZE       = 8;
    localparam int ROW_BITS        = 3;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [ROW_BITS-1:0] ROW_LAST   = ROW_BITS'(CELL_SIZE - 1);
    localparam logic [10:0]         ROW_MAX    = 11'd2047;
    localparam logic [11:0]         LINE_PITCH = 12'(CELL_SIZE + 1);
    localparam logic [7:0]          LINE_FEED  = 8'h0A;

    // opcodes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_WIDTH = 2'd2;
    localparam logic [1:0] OP_HOME  = 2'd3;

    // register indexes
    localparam int            ADDR_W       = 4;
    localparam logic [1:0] REG_FG_COLOR = 2'd0;
    localparam logic [1:0] REG_VIS_W    = 2'd1;
    localparam logic [1:0] REG_VIS_H    = 2'd2;
    localparam logic [1:0] REG_STRIDE   = 2'd3;

    localparam logic [23:0] FG_COLOR_RST = 24'hFFFFFF;
    localparam logic [9:0]  VIS_W_RST    = 10'd540;
    localparam logic [9:0]  VIS_H_RST    = 10'd960;
    localparam logic [10:0] STRIDE_RST   = 11'd544;

    typedef enum logic [2:0] {
        KIND_PUT,
        KIND_FEED,
        KIND_HOME,
        KIND_ROW,
        KIND_WIDTH
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          code;
        logic [ROW_BITS-1:0] row;
        logic [7:0]          data;
        logic                in_range;
    } t_cmd;

endpackage

// ===== hw/rtl/btc_ram.sv =====
// ----------------------------------------------------------------------------
// btc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module btc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/btc_front.sv =====
// ----------------------------------------------------------------------------
// btc_front
// Unpacks input transfers and sorts them into command kinds.
// ----------------------------------------------------------------------------
module btc_front #(
    parameter int GLYPH_COUNT = btc_pkg::GLYPH_COUNT_DEF
) (
    input  logic                 i_valid,
    input  logic [23:0]          i_data,   // char_code, glyph_row, load_data, pad
    input  logic [1:0]           i_user,   // opcode
    input  logic                 i_full,
    output logic                 o_ready,
    output logic                 o_push,
    output btc_pkg::t_cmd        o_cmd
);

    logic in_range;
    logic drop;

    always_comb begin
        in_range         = {1'b0, i_data[7:0]} < 9'(GLYPH_COUNT);
        o_cmd.code       = i_data[7:0];
        o_cmd.row        = i_data[10:8];
        o_cmd.data       = i_data[18:11];
        o_cmd.in_range   = in_range;
        drop             = 1'b0;
        unique case (i_user)
            btc_pkg::OP_PUT: begin
                o_cmd.kind = (i_data[7:0] == btc_pkg::LINE_FEED) ?
                             btc_pkg::KIND_FEED : btc_pkg::KIND_PUT;
            end
            btc_pkg::OP_ROW: begin
                o_cmd.kind = btc_pkg::KIND_ROW;
                drop       = !in_range;
            end
            btc_pkg::OP_WIDTH: begin
                o_cmd.kind = btc_pkg::KIND_WIDTH;
                drop       = !in_range;
            end
            default: begin
                o_cmd.kind = btc_pkg::KIND_HOME;
            end
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && !drop;

endmodule

// ===== hw/rtl/btc_queue.sv =====
// ----------------------------------------------------------------------------
// btc_queue
// Short command FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module btc_queue #(
    parameter int DEPTH = btc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  btc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output btc_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    btc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/btc_back.sv =====
// ----------------------------------------------------------------------------
// btc_back
// Executes commands: glyph loads, cursor moves and eight-row glyph draws.
// ----------------------------------------------------------------------------
module btc_back #(
    parameter int GLYPH_COUNT = btc_pkg::GLYPH_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  btc_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic [23:0]   i_fg_color,
    input  logic [9:0]    i_vis_w,
    input  logic [9:0]    i_vis_h,
    input  logic [10:0]   i_stride,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [19:0]   o_pixel_index,
    output logic [7:0]    o_pixel_mask,
    output logic [23:0]   o_color,
    output logic          o_last
);

    localparam int GW  = $clog2(GLYPH_COUNT);
    localparam int RB  = btc_pkg::ROW_BITS;

    typedef enum logic [1:0] {
        ST_CMD  = 2'b01,
        ST_ROWS = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [RB-1:0] r_cnt, n_cnt;
    logic [7:0]    r_code;
    logic          r_in_range;
    logic [10:0]   r_crow;
    logic [9:0]    r_ccol;
    logic [10:0]   r_cur_row;
    logic [9:0]    r_cur_col;
    logic          r_s1_valid;
    logic [RB-1:0] r_s1_row;
    logic          r_o_valid;
    logic [19:0]   r_index;
    logic [7:0]    r_mask;
    logic [23:0]   r_color;
    logic          r_last;

    logic          adv;
    logic          issue;
    logic [RB-1:0] issue_row;
    logic          bm_we;
    logic          wd_we;
    logic [7:0]    rd_code;
    logic [7:0]    bm_rdata;
    logic [7:0]    wd_rdata;
    logic          take_put;

    // draw datapath
    logic [11:0]   y;
    logic [22:0]   prod;
    logic [7:0]    colmask;
    logic [7:0]    mask;

    // cursor advance after a draw
    logic [7:0]    gw;
    logic [10:0]   ncol;
    logic          wrap;
    logic [10:0]   row_a;
    logic [10:0]   row_n;
    logic [9:0]    col_n;

    function automatic logic [10:0] row_adv(input logic [10:0] r);
        logic [11:0] s;
        s = 12'(r) + btc_pkg::LINE_PITCH;
        return (s > 12'(btc_pkg::ROW_MAX)) ? btc_pkg::ROW_MAX : s[10:0];
    endfunction

    assign adv = !r_o_valid || i_ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd_pop = 1'b0;
        issue     = 1'b0;
        issue_row = r_cnt;
        bm_we     = 1'b0;
        wd_we     = 1'b0;
        unique case (r_state)
            ST_CMD: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        btc_pkg::KIND_PUT: begin
                            if (adv) begin
                                o_cmd_pop = 1'b1;
                                issue     = 1'b1;
                                issue_row = '0;
                                n_cnt     = RB'(1);
                                n_state   = ST_ROWS;
                            end
                        end
                        btc_pkg::KIND_ROW: begin
                            o_cmd_pop = 1'b1;
                            bm_we     = 1'b1;
                        end
                        btc_pkg::KIND_WIDTH: begin
                            o_cmd_pop = 1'b1;
                            wd_we     = 1'b1;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_ROWS: begin
                if (adv) begin
                    issue = 1'b1;
                    n_cnt = RB'(r_cnt + 1'b1);
                    if (r_cnt == btc_pkg::ROW_LAST) begin
                        n_state = ST_CMD;
                    end
                end
            end
            default: begin
                n_state = ST_CMD;
            end
        endcase
    end

    assign take_put = o_cmd_pop && (i_cmd.kind == btc_pkg::KIND_PUT);
    assign rd_code  = (r_state == ST_CMD) ? i_cmd.code : r_code;

    btc_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_COUNT * btc_pkg::CELL_SIZE)
    ) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr ({i_cmd.code[GW-1:0], i_cmd.row}),
        .i_wdata (i_cmd.data),
        .i_re    (adv),
        .i_raddr ({rd_code[GW-1:0], issue_row}),
        .o_rdata (bm_rdata)
    );

    btc_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_COUNT)
    ) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (wd_we),
        .i_waddr (i_cmd.code[GW-1:0]),
        .i_wdata (i_cmd.data),
        .i_re    (adv),
        .i_raddr (rd_code[GW-1:0]),
        .o_rdata (wd_rdata)
    );

    always_comb begin
        y    = 12'(r_crow) + 12'(r_s1_row);
        prod = 23'(y * i_stride);
        for (int c = 0; c < btc_pkg::CELL_SIZE; c++) begin
            colmask[btc_pkg::CELL_SIZE-1-c] = (11'(r_ccol) + 11'(c)) < 11'(i_vis_w);
        end
        mask = (r_in_range && (y < 12'(i_vis_h))) ? (bm_rdata & colmask) : 8'd0;

        gw    = r_in_range ? wd_rdata : 8'd0;
        ncol  = 11'(r_ccol) + 11'(gw) + 11'd1;
        wrap  = (12'(ncol) + 12'(btc_pkg::CELL_SIZE)) > 12'(i_vis_w);
        row_a = wrap ? row_adv(r_cur_row) : r_cur_row;
        col_n = wrap ? 10'd0 : ncol[9:0];
        row_n = ((12'(row_a) + 12'(btc_pkg::CELL_SIZE)) > 12'(i_vis_h)) ? 11'd0 : row_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CMD;
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (adv) begin
                r_s1_valid <= issue;
                r_o_valid  <= r_s1_valid;
            end
            if (o_cmd_pop && i_cmd.kind == btc_pkg::KIND_HOME) begin
                r_cur_row <= '0;
                r_cur_col <= '0;
            end else if (o_cmd_pop && i_cmd.kind == btc_pkg::KIND_FEED) begin
                r_cur_row <= row_adv(r_cur_row);
                r_cur_col <= '0;
            end else if (adv && r_s1_valid && r_s1_row == '0) begin
                r_cur_row <= row_n;
                r_cur_col <= col_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_row <= issue_row;
        end
        if (take_put) begin
            r_code     <= i_cmd.code;
            r_in_range <= i_cmd.in_range;
            r_crow     <= r_cur_row;
            r_ccol     <= r_cur_col;
        end
        if (adv && r_s1_valid) begin
            r_index <= 20'(prod + 23'(r_ccol));
            r_mask  <= mask;
            r_color <= i_fg_color;
            r_last  <= r_s1_row == btc_pkg::ROW_LAST;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_index = r_index;
    assign o_pixel_mask  = r_mask;
    assign o_color       = r_color;
    assign o_last        = r_last;

endmodule

// ===== hw/rtl/bitmap_text_console_renderer.sv =====
// ----------------------------------------------------------------------------
// bitmap_text_console_renderer
// Text console that draws 8x8 proportional glyphs as masked row writes.
// ----------------------------------------------------------------------------
// Input transfers enter a four-entry command queue at up to one per cycle
// while it is not full. Glyph row loads, width loads, home and line feed are
// each executed as they leave the queue. A drawn character issues eight row
// writes on the result stream, one per cycle while the stream accepts them;
// that single output channel sets the sustained character rate. The first
// row write passes a read stage and an output register. Glyph rows are held
// in an 8-bit wide memory read once per row; glyphs never loaded read as undefined.
// Configuration registers must only be written while no character is pending.
module bitmap_text_console_renderer #(
    parameter int GLYPH_COUNT = btc_pkg::GLYPH_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,  // char_code, glyph_row, load_data
    input  logic [1:0]                 s_axis_tuser,  // opcode
    // result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [55:0]                m_axis_tdata,  // pixel_index, pixel_mask, color
    output logic                       m_axis_tlast,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [btc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [23:0]   r_fg_color;
    logic [9:0]    r_vis_w;
    logic [9:0]    r_vis_h;
    logic [10:0]   r_stride;

    logic          wr_en;
    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    btc_pkg::t_cmd f_cmd;
    btc_pkg::t_cmd q_cmd;
    logic [19:0]   pixel_index;
    logic [7:0]    pixel_mask;
    logic [23:0]   color;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color <= btc_pkg::FG_COLOR_RST;
            r_vis_w    <= btc_pkg::VIS_W_RST;
            r_vis_h    <= btc_pkg::VIS_H_RST;
            r_stride   <= btc_pkg::STRIDE_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                btc_pkg::REG_FG_COLOR: r_fg_color <= pwdata[23:0];
                btc_pkg::REG_VIS_W:    r_vis_w    <= pwdata[9:0];
                btc_pkg::REG_VIS_H:    r_vis_h    <= pwdata[9:0];
                default:               r_stride   <= pwdata[10:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            btc_pkg::REG_FG_COLOR: prdata = 32'(r_fg_color);
            btc_pkg::REG_VIS_W:    prdata = 32'(r_vis_w);
            btc_pkg::REG_VIS_H:    prdata = 32'(r_vis_h);
            default:               prdata = 32'(r_stride);
        endcase
    end

    btc_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_full  (q_full),
        .o_ready (s_axis_tready),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    btc_queue #(
        .DEPTH (btc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    btc_back #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (q_pop),
        .i_fg_color    (r_fg_color),
        .i_vis_w       (r_vis_w),
        .i_vis_h       (r_vis_h),
        .i_stride      (r_stride),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_pixel_index (pixel_index),
        .o_pixel_mask  (pixel_mask),
        .o_color       (color),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, color, pixel_mask, pixel_index};

endmodule
